// ===== hdl/escape_rle_encoder_unit_assert.svh =====
// assertion macros for the escape run-length encoder
`ifndef ESCAPE_RLE_ENCODER_UNIT_ASSERT_SVH
`define ESCAPE_RLE_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ERLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ERLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/erle_pkg.sv =====
// shared types and constants of the escape run-length encoder
package erle_pkg;

  localparam int BURST_MAX = 8;
  localparam int CNT_W     = 4;

  // register indexes
  localparam logic [1:0] REG_ESCAPE_CODE = 2'd0;
  localparam logic [1:0] REG_MIN_RUN     = 2'd1;
  localparam logic [1:0] REG_MAX_RUN     = 2'd2;

  // reset values and limits
  localparam logic [7:0] ESCAPE_RESET  = 8'hED;
  localparam logic [7:0] MIN_RUN_RESET = 8'd4;
  localparam logic [7:0] MAX_RUN_RESET = 8'd240;
  localparam logic [2:0] MIN_RUN_CAP   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
    logic       add_terminator;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_burst;
  } out_item_t;

  // effective configuration
  typedef struct packed {
    logic [7:0] escape_code;
    logic [2:0] eff_min;
    logic [7:0] eff_max;
  } cfg_t;

  // bytes caused by one item
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
  } burst_t;

  // status of the output buffer
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             busy;
  } obuf_stat_t;

endpackage

// ===== hdl/erle_cfg_regs.sv =====
// configuration registers and their effective values
module erle_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_wdata,
  output erle_pkg::cfg_t   cfg
);
  import erle_pkg::*;

  logic [7:0] escape_r, min_run_r, max_run_r;

  // register writes, other indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r  <= ESCAPE_RESET;
      min_run_r <= MIN_RUN_RESET;
      max_run_r <= MAX_RUN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ESCAPE_CODE: escape_r  <= cfg_wdata;
        REG_MIN_RUN:     min_run_r <= cfg_wdata;
        REG_MAX_RUN:     max_run_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // minimum capped at four, zero maximum acts as one
  always_comb begin
    cfg.escape_code = escape_r;
    cfg.eff_min     = (min_run_r > {5'd0, MIN_RUN_CAP}) ? MIN_RUN_CAP : min_run_r[2:0];
    cfg.eff_max     = (max_run_r == 8'd0) ? 8'd1 : max_run_r;
  end

endmodule

// ===== hdl/erle_burst.sv =====
// run state and coding of the bytes caused by one item
module erle_burst (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  erle_pkg::in_item_t item,
  input  erle_pkg::cfg_t     cfg,
  output erle_pkg::burst_t   burst,
  output logic               run_open
);
  import erle_pkg::*;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      n;
  } seg_t;

  logic [7:0] run_value_r, run_value_nxt;
  logic [7:0] run_length_r, run_length_nxt;

  logic       close_old, extend, close_new;
  logic [7:0] new_len, new_val;
  seg_t       seg_old, seg_new, seg_term;

  // triple or literal copies for one closed run
  function automatic seg_t close_seg(input logic [7:0] val, input logic [7:0] len,
                                     input cfg_t c, input logic en);
    seg_t s;
    if (len >= {5'd0, c.eff_min} || val == c.escape_code) begin
      s.b = {val, len, c.escape_code};
      s.n = 2'd3;
    end else begin
      s.b = {val, val, val};
      s.n = len[1:0];
    end
    if (!en) begin
      s.n = 2'd0;
    end
    return s;
  endfunction

  // run decisions
  always_comb begin
    close_old = (run_length_r != 8'd0) &&
                (item.data_byte != run_value_r || run_length_r >= cfg.eff_max);
    extend    = (run_length_r != 8'd0) && !close_old;
    new_len   = extend ? run_length_r + 8'd1 : 8'd1;
    new_val   = extend ? run_value_r : item.data_byte;
    close_new = (new_len >= cfg.eff_max) || item.block_end;

    seg_old  = close_seg(run_value_r, run_length_r, cfg, close_old);
    seg_new  = close_seg(new_val, new_len, cfg, close_new);
    seg_term.b = {8'd0, 8'd0, cfg.escape_code};
    seg_term.n = (item.block_end && item.add_terminator) ? 2'd2 : 2'd0;

    run_value_nxt  = new_val;
    run_length_nxt = close_new ? 8'd0 : new_len;
  end

  // pack the three segments back to back
  always_comb begin
    logic [CNT_W-1:0] pos, o1, o2, rel;
    rel = '0;
    o1 = {2'd0, seg_old.n};
    o2 = o1 + {2'd0, seg_new.n};
    burst.cnt = o2 + {2'd0, seg_term.n};
    for (int p = 0; p < BURST_MAX; p++) begin
      pos = CNT_W'(p);
      if (pos < o1) begin
        burst.bytes[p] = seg_old.b[pos[1:0]];
      end else if (pos < o2) begin
        rel = pos - o1;
        burst.bytes[p] = seg_new.b[rel[1:0]];
      end else begin
        rel = pos - o2;
        burst.bytes[p] = seg_term.b[rel[1:0]];
      end
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_value_r  <= 8'd0;
      run_length_r <= 8'd0;
    end else if (load) begin
      run_value_r  <= run_value_nxt;
      run_length_r <= run_length_nxt;
    end
  end

  assign run_open = (run_length_r != 8'd0);

endmodule

// ===== hdl/erle_obuf.sv =====
// result buffer; shifts out a burst byte per unstalled cycle
module erle_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  erle_pkg::burst_t      burst,
  input  logic                  out_stall,
  output logic                  out_valid,
  output erle_pkg::out_item_t   out_item,
  output erle_pkg::obuf_stat_t  stat
);
  import erle_pkg::*;

  logic [BURST_MAX-1:0][7:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      take;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && !out_stall;

  // head of the shift line is the current result
  assign out_item.code_byte     = buf_r[0];
  assign out_item.last_of_burst = (cnt_r == CNT_W'(1));

  // busy unless empty or the last byte leaves now
  assign stat.cnt  = cnt_r;
  assign stat.busy = (cnt_r > CNT_W'(1)) || (cnt_r == CNT_W'(1) && out_stall);

  // load a new burst or shift on each taken byte
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = burst.bytes;
      cnt_nxt = burst.cnt;
    end else if (take) begin
      for (int i = 0; i < BURST_MAX - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/escape_rle_encoder_unit.sv =====
// top level of the escape run-length encoder
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_item   (data_byte, block_end, add_terminator)
//  out_     output     out_valid/out_stall  out_item  (code_byte, last_of_burst)
//  cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// an item is coded in the cycle it is accepted and its bytes land in an
// eight-byte shift buffer; the out side drains that buffer one byte per unstalled cycle
// an item causing more than one byte holds in_stall until its last byte leaves, longer
// while out_stall holds bytes; one item per cycle while each causes <= 1 byte, out_stall low
// in_stall may depend on out_stall; valid never depends on stall
// synchronous active-low reset clears the run, the buffer count and the registers
module escape_rle_encoder_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  erle_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output erle_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata
);
  import erle_pkg::*;

  cfg_t       cfg;
  burst_t     burst;
  obuf_stat_t stat;
  logic       in_accept;
  logic       run_open;

  assign in_stall  = stat.busy;
  assign in_accept = in_valid && !in_stall;

  erle_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  erle_burst u_burst (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_accept),
    .item     (in_item),
    .cfg      (cfg),
    .burst    (burst),
    .run_open (run_open)
  );

  erle_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .burst     (burst),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (stat)
  );

  `include "escape_rle_encoder_unit_assert.svh"

  // checks
  `ERLE_ASSERT_NOW(a_stall_when_full, stat.cnt > CNT_W'(1), in_stall, "input taken over a burst")
  `ERLE_ASSERT_NEXT(a_burst_shown, in_accept && burst.cnt != '0, out_valid, "burst lost")
  `ERLE_ASSERT_NEXT(a_block_end_flush, in_accept && in_item.block_end, !run_open, "run left open")

endmodule

// ===== dv/escape_rle_encoder_unit_test.sv =====
// self-checking testbench for the escape run-length encoder
module escape_rle_encoder_unit_test;
  import erle_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int CHUNK_ITEMS    = 65;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_ESCAPE_CODE;
  logic [7:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int errors        = 0;

  // encoder state as predicted by the testbench
  logic [7:0] esc_reg;
  logic [7:0] min_reg;
  logic [7:0] max_reg;
  logic [7:0] run_byte;
  logic [7:0] run_len;
  out_item_t  burst_q[$];
  out_item_t  code_q[$];

  escape_rle_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_code(input logic [7:0] b);
    burst_q.push_back('{code_byte: b, last_of_burst: 1'b0});
  endfunction

  // close the open run as a coded triple or as literal copies
  function automatic void close_open_run();
    logic [7:0] min_eff;
    min_eff = (min_reg > 8'(MIN_RUN_CAP)) ? 8'(MIN_RUN_CAP) : min_reg;
    if (run_len == 8'd0) return;
    if (run_len >= min_eff || run_byte == esc_reg) begin
      push_code(esc_reg);
      push_code(run_len);
      push_code(run_byte);
    end else begin
      for (int i = 0; i < int'(run_len); i++) push_code(run_byte);
    end
    run_len = 8'd0;
  endfunction

  // code bytes caused by one raw byte, appended to the expected stream
  function automatic void rle_encode_item(input in_item_t it);
    logic [7:0] max_eff;
    out_item_t  code;
    max_eff = (max_reg == 8'd0) ? 8'd1 : max_reg;
    burst_q.delete();
    if (run_len != 8'd0 && (it.data_byte != run_byte || run_len >= max_eff))
      close_open_run();
    if (run_len != 8'd0) begin
      run_len = run_len + 8'd1;
    end else begin
      run_byte = it.data_byte;
      run_len  = 8'd1;
    end
    if (run_len >= max_eff) close_open_run();
    if (it.block_end) begin
      close_open_run();
      if (it.add_terminator) begin
        push_code(esc_reg);
        push_code(8'h00);
      end
    end
    foreach (burst_q[i]) begin
      code = burst_q[i];
      code.last_of_burst = (i == burst_q.size() - 1);
      code_q.push_back(code);
    end
  endfunction

  // predict on accepted items and register writes, check accepted results
  always @(posedge clk) begin : monitor
    out_item_t exp_code;
    if (!rst_n) begin
      esc_reg  = ESCAPE_RESET;
      min_reg  = MIN_RUN_RESET;
      max_reg  = MAX_RUN_RESET;
      run_byte = 8'd0;
      run_len  = 8'd0;
      code_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ESCAPE_CODE: esc_reg = cfg_wdata;
          REG_MIN_RUN:     min_reg = cfg_wdata;
          REG_MAX_RUN:     max_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) rle_encode_item(in_item);
      if (out_valid && !out_stall) begin
        if (code_q.size() == 0) begin
          $error("unexpected code byte %02h", out_item.code_byte);
          errors++;
        end else begin
          exp_code = code_q.pop_front();
          if (exp_code.code_byte !== out_item.code_byte) begin
            $error("code_byte: expected %02h, got %02h",
                   exp_code.code_byte, out_item.code_byte);
            errors++;
          end
          if (exp_code.last_of_burst !== out_item.last_of_burst) begin
            $error("last_of_burst: expected %0b, got %0b",
                   exp_code.last_of_burst, out_item.last_of_burst);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall: long hold-off when requested, else random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // maybe idle a few cycles, then offer one item and wait for it to be taken
  task automatic send_item(input logic [7:0] b, input logic blk_end, input logic term);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= '{data_byte: b, block_end: blk_end, add_terminator: term};
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // stop sending and wait until every expected byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (code_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] esc, input logic [7:0] mn,
                              input logic [7:0] mx);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ESCAPE_CODE;
    cfg_wdata <= esc;
    @(posedge clk);
    cfg_index <= REG_MIN_RUN;
    cfg_wdata <= mn;
    @(posedge clk);
    cfg_index <= REG_MAX_RUN;
    cfg_wdata <= mx;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // hand-picked items, mostly at the reset settings
  task automatic test_directed_cases();
    // lone escape byte is always coded
    send_item(8'hED, 1'b1, 1'b0);
    // short literal run followed by end marker
    send_item(8'h11, 1'b0, 1'b0);
    send_item(8'h11, 1'b0, 1'b0);
    send_item(8'h11, 1'b1, 1'b1);
    // terminator ignored without block end, then a new byte's run is flushed
    send_item(8'h22, 1'b0, 1'b1);
    send_item(8'h33, 1'b1, 1'b0);
    // fullest burst: three literals, coded escape, end marker
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    wait_drained();
    program_regs(8'hED, 8'd4, 8'd1);
    send_item(8'hED, 1'b1, 1'b1);
    wait_drained();
    // maximum lowered under an open run
    program_regs(8'hED, 8'd4, 8'd240);
    repeat (4) send_item(8'h44, 1'b0, 1'b0);
    wait_drained();
    program_regs(8'hED, 8'd4, 8'd3);
    send_item(8'h44, 1'b0, 1'b0);
    send_item(8'h44, 1'b1, 1'b0);
    wait_drained();
  endtask

  // register values at and beyond their limits
  task automatic test_register_extremes();
    // zero minimum and zero maximum: every byte is its own triple
    program_regs(8'h00, 8'd0, 8'd0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b1);
    wait_drained();
    // minimum of one and widest maximum
    program_regs(8'hFF, 8'd1, 8'd255);
    send_item(8'h12, 1'b0, 1'b0);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    wait_drained();
    // large minimum behaves as four
    program_regs(8'h5A, 8'd255, 8'd255);
    repeat (3) send_item(8'h77, 1'b0, 1'b0);
    send_item(8'h77, 1'b1, 1'b0);
    repeat (2) send_item(8'h66, 1'b0, 1'b0);
    send_item(8'h66, 1'b1, 1'b0);
    wait_drained();
  endtask

  // mostly runs of equal bytes with random content, some noise
  task automatic send_random_runs(input int n_items);
    int         sent;
    int         len;
    logic [7:0] val;
    logic       blk_last;
    logic       term;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        case ($urandom_range(9))
          0, 1:    val = esc_reg;
          2, 3, 4: val = 8'($urandom_range(3));
          default: val = 8'($urandom_range(255));
        endcase
        len      = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 20);
        blk_last = ($urandom_range(3) == 0);
        term     = 1'($urandom_range(1));
        for (int i = 0; i < len; i++)
          send_item(val, blk_last && (i == len - 1), term && (i == len - 1));
        sent += len;
      end
    end
    wait_drained();
  endtask

  // two random register settings under one idling pattern
  task automatic test_random_mix(input int snd_pct, input int rcv_pct);
    logic [7:0] mn;
    logic [7:0] mx;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (2) begin
      mn = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
      case ($urandom_range(9))
        0:       mx = 8'd0;
        1:       mx = 8'd255;
        default: mx = 8'($urandom_range(1, 12));
      endcase
      program_regs(8'($urandom_range(255)), mn, mx);
      send_random_runs(CHUNK_ITEMS);
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(8'hED, 8'd2, 8'd1);
    hold_left <= HOLD_CYCLES;
    repeat (30) send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 33;
    recv_idle_pct = 62;
    test_directed_cases();
    test_register_extremes();
    test_random_mix(33, 62);
    test_random_mix(62, 33);
    test_random_mix(0, 0);
    test_backpressure();
    repeat (20) @(posedge clk);
    if (errors == 0 && code_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== escape_rle_encoder_unit.f =====
+incdir+hdl
hdl/erle_pkg.sv
hdl/erle_cfg_regs.sv
hdl/erle_burst.sv
hdl/erle_obuf.sv
hdl/escape_rle_encoder_unit.sv
dv/escape_rle_encoder_unit_test.sv
